/* sv/bsc_pkg.sv */
package bsc_pkg;

    localparam int unsigned DataW   = 32;
    localparam int unsigned RawW    = 24;
    localparam int unsigned AddrW   = 5;
    localparam int unsigned PDataW  = 64;

    localparam logic [AddrW-1:0] AddrCalA = 5'd0;
    localparam logic [AddrW-1:0] AddrCalB = 5'd8;
    localparam logic [AddrW-1:0] AddrCalC = 5'd16;
    localparam logic [AddrW-1:0] AddrOss  = 5'd24;

    localparam logic signed [31:0] Const4000  = 32'sd4000;
    localparam logic signed [31:0] Const32768 = 32'sd32768;
    localparam logic [31:0]        Const50000 = 32'd50000;
    localparam logic signed [31:0] Const3038  = 32'sd3038;
    localparam logic signed [31:0] ConstM7357 = -32'sd7357;
    localparam logic signed [31:0] Const3791  = 32'sd3791;

    typedef enum logic [4:0] {
        S_IDLE,
        S_T_X1,
        S_T_DEN,
        S_T_DIV,
        S_T_FIN,
        S_P_B6,
        S_P_SQ,
        S_P_X1,
        S_P_X2,
        S_P_B3A,
        S_P_B3,
        S_P_X1B,
        S_P_X2B,
        S_P_B4,
        S_P_B7,
        S_P_DIV,
        S_P_PQ,
        S_P_F1,
        S_P_F2,
        S_P_F3,
        S_P_FIN,
        S_OUT
    } t_state;

    typedef struct packed {
        logic [4:0] step;
        logic       div_start;
    } t_cmd;

    typedef struct packed {
        logic den_zero;
        logic div_done;
    } t_sts;

endpackage

/* sv/bsc_if.sv */
interface bsc_in_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [23:0] raw_reading;
    modport source (output valid, req_type, raw_reading, input ready);
    modport sink (input valid, req_type, raw_reading, output ready);
endinterface

interface bsc_out_if;
    logic               valid;
    logic               ready;
    logic               result_kind;
    logic signed [31:0] result_value;
    logic               status;
    modport source (output valid, result_kind, result_value, status, input ready);
    modport sink (input valid, result_kind, result_value, status, output ready);
endinterface

/* sv/bsc_div.sv */
module bsc_div
    import bsc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_num,
    input  logic [31:0] i_den,
    output logic        o_done,
    output logic [31:0] o_quot
);
    logic [31:0] r_q, n_q;
    logic [31:0] r_rem, n_rem;
    logic [31:0] r_den;
    logic [5:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy;
    logic [32:0] w_trial;

    always_comb begin
        n_q    = r_q;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        w_trial = {r_rem, r_q[31]} - {1'b0, r_den};
        if (i_start) begin
            n_q    = i_num;
            n_rem  = '0;
            n_cnt  = 6'd32;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (!w_trial[32]) begin
                n_rem = w_trial[31:0];
                n_q   = {r_q[30:0], 1'b1};
            end else begin
                n_rem = {r_rem[30:0], r_q[31]};
                n_q   = {r_q[30:0], 1'b0};
            end
            n_cnt = r_cnt - 6'd1;
            if (r_cnt == 6'd1) n_busy = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
        r_q   <= n_q;
        r_rem <= n_rem;
        if (i_start) r_den <= i_den;
    end

    assign o_done = r_busy && (r_cnt == 6'd1);
    assign o_quot = n_q;
endmodule

/* sv/bsc_datapath.sv */
module bsc_datapath
    import bsc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    input  logic               i_load,
    input  logic [23:0]        i_raw,
    input  logic [63:0]        i_cal_a,
    input  logic [63:0]        i_cal_b,
    input  logic [31:0]        i_cal_c,
    input  logic [1:0]         i_oss,
    output t_sts               o_sts,
    output logic signed [31:0] o_value,
    output logic               o_status
);
    logic signed [31:0] ac1, ac2, ac3, b1, b2, mc, md;
    logic [31:0] ac4, ac5, ac6;
    logic signed [31:0] r_b5, r_a, r_b, r_c, r_d, r_e, r_val, r_up;
    logic [31:0] r_b4, r_b7;
    logic        r_st;
    logic [23:0] r_raw;
    logic        w_div_done;
    logic [31:0] w_quot, w_num, w_den, w_abs_n, w_abs_d;
    logic signed [63:0] w_m;
    logic signed [31:0] w_mx, w_my, w_pq;
    logic [31:0] w_p32;

    assign ac1 = 32'(signed'(i_cal_a[15:0]));
    assign ac2 = 32'(signed'(i_cal_a[31:16]));
    assign ac3 = 32'(signed'(i_cal_a[47:32]));
    assign ac4 = {16'd0, i_cal_a[63:48]};
    assign ac5 = {16'd0, i_cal_b[15:0]};
    assign ac6 = {16'd0, i_cal_b[31:16]};
    assign b1  = 32'(signed'(i_cal_b[47:32]));
    assign b2  = 32'(signed'(i_cal_b[63:48]));
    assign mc  = 32'(signed'(i_cal_c[15:0]));
    assign md  = 32'(signed'(i_cal_c[31:16]));

    always_comb begin
        w_mx = '0;
        w_my = '0;
        unique case (i_cmd.step)
            S_T_X1:  begin w_mx = $signed({16'd0, r_raw[15:0]}) - $signed(ac6);
                           w_my = $signed(ac5); end
            S_P_SQ:  begin w_mx = r_a; w_my = r_a; end
            S_P_X1:  begin w_mx = b2; w_my = r_b; end
            S_P_X2:  begin w_mx = ac2; w_my = r_a; end
            S_P_X1B: begin w_mx = ac3; w_my = r_a; end
            S_P_X2B: begin w_mx = b1; w_my = r_b; end
            S_P_B4:  begin w_mx = $signed(ac4); w_my = r_c + Const32768; end
            S_P_B7:  begin w_mx = r_up - r_d; w_my = $signed(Const50000 >> i_oss); end
            S_P_F1:  begin w_mx = r_val >>> 8; w_my = r_val >>> 8; end
            S_P_F2:  begin w_mx = r_a; w_my = Const3038; end
            S_P_F3:  begin w_mx = ConstM7357; w_my = r_val; end
            default: begin w_mx = '0; w_my = '0; end
        endcase
        w_m = w_mx * w_my;
    end

    assign w_abs_n = mc[31] ? 32'(-(mc <<< 11)) : 32'(mc <<< 11);
    assign w_abs_d = r_a[31] ? 32'(-r_a) : r_a;
    assign w_num = (i_cmd.step == S_T_DIV) ? w_abs_n :
                   (r_b7[31] ? r_b7 : {r_b7[30:0], 1'b0});
    assign w_den = (i_cmd.step == S_T_DIV) ? w_abs_d : r_b4;
    assign w_p32 = r_b7[31] ? {w_quot[30:0], 1'b0} : w_quot;
    assign w_pq  = ((mc[31] ^ r_a[31]) ? 32'(-w_quot) : w_quot);

    bsc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b5 <= '0;
        end else if (i_cmd.step == S_T_FIN && !r_st) begin
            r_b5 <= r_b;
        end
        if (i_load) begin
            r_raw <= i_raw;
            r_st  <= 1'b0;
            r_val <= '0;
            r_up  <= $signed({8'd0, i_raw >> (4'd8 - {2'b0, i_oss})});
        end
        unique case (i_cmd.step)
            S_T_X1:  r_a <= $signed(w_m[31:0]) >>> 15;
            S_T_DEN: begin r_a <= r_a + md; r_c <= r_a; end
            S_T_DIV: if (r_a == 0) r_st <= 1'b1;
                     else if (w_div_done) r_b <= r_c + w_pq;
            S_T_FIN: if (!r_st) r_val <= (r_b + 32'sd8) >>> 4;
            S_P_B6:  r_a <= r_b5 - Const4000;
            S_P_SQ:  r_b <= $signed(w_m[31:0]) >>> 12;
            S_P_X1:  r_c <= $signed(w_m[31:0]) >>> 11;
            S_P_X2:  r_c <= r_c + ($signed(w_m[31:0]) >>> 11);
            S_P_B3A: r_d <= (ac1 <<< 2) + r_c;
            S_P_B3:  r_d <= ((r_d <<< i_oss) + 32'sd2) >>> 2;
            S_P_X1B: r_c <= $signed(w_m[31:0]) >>> 13;
            S_P_X2B: r_c <= (r_c + ($signed(w_m[31:0]) >>> 16) + 32'sd2) >>> 2;
            S_P_B4:  r_b4 <= w_m[31:0] >> 15;
            S_P_B7:  r_b7 <= w_m[31:0];
            S_P_DIV: if (r_b4 == 0) r_st <= 1'b1;
                     else if (w_div_done) r_val <= w_p32;
            S_P_F1:  r_a <= w_m[31:0];
            S_P_F2:  r_a <= $signed(w_m[31:0]) >>> 16;
            S_P_F3:  r_e <= $signed(w_m[31:0]) >>> 16;
            S_P_FIN: if (!r_st) r_val <= r_val + ((r_a + r_e + Const3791) >>> 4);
            default: ;
        endcase
    end

    assign o_sts.den_zero = (i_cmd.step == S_T_DIV) ? (r_a == 0) : (r_b4 == 0);
    assign o_sts.div_done = w_div_done;
    assign o_value  = r_st ? '0 : r_val;
    assign o_status = r_st;
endmodule

/* sv/bsc_ctrl.sv */
module bsc_ctrl
    import bsc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_req_type,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output logic o_in_ready,
    output logic o_out_valid,
    output logic o_load,
    output t_cmd o_cmd
);
    t_state r_state, n_state;
    logic   r_started, n_started;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_started <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_started <= n_started;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_started = r_started;
        o_in_ready  = (r_state == S_IDLE);
        o_out_valid = (r_state == S_OUT);
        o_load      = 1'b0;
        o_cmd.step  = r_state;
        o_cmd.div_start = 1'b0;
        unique case (r_state)
            S_IDLE: if (i_in_valid) begin
                o_load  = 1'b1;
                n_state = i_req_type ? S_P_B6 : S_T_X1;
            end
            S_T_X1:  n_state = S_T_DEN;
            S_T_DEN: n_state = S_T_DIV;
            S_T_DIV, S_P_DIV: begin
                if (i_sts.den_zero) begin
                    n_state   = (r_state == S_T_DIV) ? S_T_FIN : S_OUT;
                    n_started = 1'b0;
                end else if (!r_started) begin
                    o_cmd.div_start = 1'b1;
                    n_started = 1'b1;
                end else if (i_sts.div_done) begin
                    n_started = 1'b0;
                    n_state   = (r_state == S_T_DIV) ? S_T_FIN : S_P_PQ;
                end
            end
            S_T_FIN: n_state = S_OUT;
            S_P_B6:  n_state = S_P_SQ;
            S_P_SQ:  n_state = S_P_X1;
            S_P_X1:  n_state = S_P_X2;
            S_P_X2:  n_state = S_P_B3A;
            S_P_B3A: n_state = S_P_B3;
            S_P_B3:  n_state = S_P_X1B;
            S_P_X1B: n_state = S_P_X2B;
            S_P_X2B: n_state = S_P_B4;
            S_P_B4:  n_state = S_P_B7;
            S_P_B7:  n_state = S_P_DIV;
            S_P_PQ:  n_state = S_P_F1;
            S_P_F1:  n_state = S_P_F2;
            S_P_F2:  n_state = S_P_F3;
            S_P_F3:  n_state = S_P_FIN;
            S_P_FIN: n_state = S_OUT;
            S_OUT:   if (i_out_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end
endmodule

/* sv/barometric_sensor_compensation_unit.sv */
// Barometer compensation: temperature and pressure transactions both use the shared radix-2
// divider, and a zero divisor skips the divider. One transaction is in flight at a time, the
// result is held until taken and the input is ready the cycle after. Calibration words sit at
// APB addresses 0, 8, 16 and the oversampling setting at 24.
module barometric_sensor_compensation_unit
    import bsc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [AddrW-1:0]  paddr,
    input  logic [PDataW-1:0] pwdata,
    output logic [PDataW-1:0] prdata,
    output logic              pready,
    bsc_in_if.sink            in_if,
    bsc_out_if.source         out_if
);
    logic [63:0] r_cal_a, r_cal_b;
    logic [31:0] r_cal_c;
    logic [1:0]  r_oss;
    logic        r_kind;
    logic        w_load;
    t_cmd        w_cmd;
    t_sts        w_sts;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_a <= '0;
            r_cal_b <= '0;
            r_cal_c <= '0;
            r_oss   <= '0;
        end else if (psel && penable && pwrite) begin
            priority case (paddr)
                AddrCalA: r_cal_a <= pwdata;
                AddrCalB: r_cal_b <= pwdata;
                AddrCalC: r_cal_c <= pwdata[31:0];
                AddrOss:  r_oss   <= pwdata[1:0];
                default:  ;
            endcase
        end
    end

    always_comb begin
        priority case (paddr)
            AddrCalA: prdata = r_cal_a;
            AddrCalB: prdata = r_cal_b;
            AddrCalC: prdata = {32'd0, r_cal_c};
            AddrOss:  prdata = {62'd0, r_oss};
            default:  prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_load) r_kind <= in_if.req_type;
    end

    bsc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_if.valid),
        .i_req_type  (in_if.req_type),
        .i_out_ready (out_if.ready),
        .i_sts       (w_sts),
        .o_in_ready  (in_if.ready),
        .o_out_valid (out_if.valid),
        .o_load      (w_load),
        .o_cmd       (w_cmd)
    );

    bsc_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_load     (w_load),
        .i_raw      (in_if.raw_reading),
        .i_cal_a    (r_cal_a),
        .i_cal_b    (r_cal_b),
        .i_cal_c    (r_cal_c),
        .i_oss      (r_oss),
        .o_sts      (w_sts),
        .o_value    (out_if.result_value),
        .o_status   (out_if.status)
    );

    assign out_if.result_kind = r_kind;
endmodule
